// ----- hw/rtl/ect_pkg.sv -----
// ---------------------------------------------------------------------------
// ect_pkg
// Shared types for the ear clipping triangulator: points and cross results.
// ---------------------------------------------------------------------------
package ect_pkg;

  localparam int unsigned CoordW = 16;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
  } point_t;

  typedef struct packed {
    logic done;
    logic neg;
    logic pos;
  } cross_res_t;

endpackage

// ----- hw/rtl/ear_clipping_triangulator_core.sv -----
// ---------------------------------------------------------------------------
// ear_clipping_triangulator_core
// Stores polygon vertices, then cuts the polygon into triangles by ear
// clipping (clockwise winding) with one shared cross product unit.
// ---------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid/in_stall   | vertex_x, vertex_y, final_vertex
//  out_    | output    | out_valid/out_stall | triangle corners and flags
//
//  After the final beat the block stalls its input while clipping: each
//  cross product runs in the shared multiplier unit, and each containment
//  test takes three of them plus a fetch of the point; entries are shifted
//  down when an ear is removed. Reset is synchronous on rst_n; the vertex
//  memory needs no clearing. An output stall holds the result register and,
//  while a triangle or the final flag waits to be sent, the clipping too.
// ---------------------------------------------------------------------------
module ear_clipping_triangulator_core #(
  parameter int unsigned MAX_VERTICES = 64
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [ect_pkg::CoordW-1:0] in_vertex_x,
  input  logic signed [ect_pkg::CoordW-1:0] in_vertex_y,
  input  logic in_final_vertex,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [ect_pkg::CoordW-1:0] out_first_x,
  output logic signed [ect_pkg::CoordW-1:0] out_first_y,
  output logic signed [ect_pkg::CoordW-1:0] out_middle_x,
  output logic signed [ect_pkg::CoordW-1:0] out_middle_y,
  output logic signed [ect_pkg::CoordW-1:0] out_third_x,
  output logic signed [ect_pkg::CoordW-1:0] out_third_y,
  output logic out_triangle_valid,
  output logic out_incomplete,
  output logic out_last_triangle
);
  import ect_pkg::*;

  localparam int unsigned IW = $clog2(MAX_VERTICES);
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_VERTICES);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_R0    = 4'd2;
  localparam logic [3:0] S_R1    = 4'd3;
  localparam logic [3:0] S_R2    = 4'd4;
  localparam logic [3:0] S_R3    = 4'd5;
  localparam logic [3:0] S_CV    = 4'd6;
  localparam logic [3:0] S_JCHK  = 4'd7;
  localparam logic [3:0] S_JRD   = 4'd8;
  localparam logic [3:0] S_XS    = 4'd9;
  localparam logic [3:0] S_XW    = 4'd10;
  localparam logic [3:0] S_NEXTI = 4'd11;
  localparam logic [3:0] S_EMIT  = 4'd12;
  localparam logic [3:0] S_SHR   = 4'd13;
  localparam logic [3:0] S_SHW   = 4'd14;
  localparam logic [3:0] S_FIN   = 4'd15;

  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, n_r, n_nxt;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt, s_r, s_nxt;
  logic [1:0]    k_r, k_nxt;
  logic          ovf_r, ovf_nxt, inc_r, inc_nxt;
  logic          nacc_r, nacc_nxt, pacc_r, pacc_nxt;
  logic          pend_v_r, pend_v_nxt;
  point_t        a_r, b_r, c_r, p_r, pa_r, pb_r, pc_r;
  logic          cap_a, cap_b, cap_c, cap_p, cap_pend;
  logic [CW-1:0] pv, nx;

  logic          we;
  logic [IW-1:0] waddr, raddr;
  point_t        wdata, rdata;

  logic          x_start;
  point_t        xa, xb, xc;
  cross_res_t    xres;

  logic          out_free, out_load;
  logic          out_valid_r;
  point_t        of_r, om_r, ot_r, of_nxt, om_nxt, ot_nxt;
  logic          otv_r, oinc_r, olast_r, otv_nxt, oinc_nxt, olast_nxt;
  logic          in_acc;

  assign pv = (i_r == '0) ? n_r - CW'(1) : i_r - CW'(1);
  assign nx = (i_r == n_r - CW'(1)) ? '0 : i_r + CW'(1);

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  ect_ram #(.WIDTH(2*CoordW), .DEPTH(MAX_VERTICES)) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  ect_cross u_cross (
    .clk  (clk),
    .rst_n(rst_n),
    .start(x_start),
    .a    (xa),
    .b    (xb),
    .c    (xc),
    .res  (xres)
  );

  always_comb begin
    xa = a_r;
    xb = b_r;
    xc = c_r;
    if (state_r == S_XS) begin
      xa = p_r;
      case (k_r)
        2'd0: begin xb = a_r; xc = b_r; end
        2'd1: begin xb = b_r; xc = c_r; end
        default: begin xb = c_r; xc = a_r; end
      endcase
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    n_nxt      = n_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    s_nxt      = s_r;
    k_nxt      = k_r;
    ovf_nxt    = ovf_r;
    inc_nxt    = inc_r;
    nacc_nxt   = nacc_r;
    pacc_nxt   = pacc_r;
    pend_v_nxt = pend_v_r;
    cap_a = 1'b0; cap_b = 1'b0; cap_c = 1'b0; cap_p = 1'b0; cap_pend = 1'b0;
    we      = 1'b0;
    waddr   = cnt_r[IW-1:0];
    wdata.x = in_vertex_x;
    wdata.y = in_vertex_y;
    raddr   = i_r[IW-1:0];
    x_start = 1'b0;
    out_load  = 1'b0;
    of_nxt    = pend_v_r ? pa_r : '0;
    om_nxt    = pend_v_r ? pb_r : '0;
    ot_nxt    = pend_v_r ? pc_r : '0;
    otv_nxt   = pend_v_r;
    oinc_nxt  = 1'b0;
    olast_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (cnt_r < MaxCnt) begin
            we      = 1'b1;
            cnt_nxt = cnt_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_final_vertex) begin
            n_nxt      = (cnt_r < MaxCnt) ? cnt_r + CW'(1) : cnt_r;
            inc_nxt    = ovf_r || !(cnt_r < MaxCnt);
            pend_v_nxt = 1'b0;
            state_nxt  = S_START;
          end
        end
      end
      S_START: begin
        i_nxt     = '0;
        state_nxt = (n_r < CW'(3)) ? S_FIN : S_R0;
      end
      S_R0: begin
        raddr     = pv[IW-1:0];
        state_nxt = S_R1;
      end
      S_R1: begin
        cap_a     = 1'b1;
        raddr     = i_r[IW-1:0];
        state_nxt = S_R2;
      end
      S_R2: begin
        cap_b     = 1'b1;
        raddr     = nx[IW-1:0];
        state_nxt = S_R3;
      end
      S_R3: begin
        cap_c     = 1'b1;
        x_start   = 1'b0;
        state_nxt = S_CV;
      end
      S_CV: begin
        if (k_r == 2'd3) begin
          if (xres.done) begin
            k_nxt = 2'd0;
            if (xres.neg) begin
              j_nxt     = '0;
              state_nxt = S_JCHK;
            end else begin
              state_nxt = S_NEXTI;
            end
          end
        end else begin
          x_start = 1'b1;
          k_nxt   = 2'd3;
        end
      end
      S_JCHK: begin
        raddr = j_r[IW-1:0];
        if (j_r == n_r) begin
          state_nxt = S_EMIT;
        end else if (j_r == i_r || j_r == pv || j_r == nx) begin
          j_nxt = j_r + CW'(1);
        end else begin
          state_nxt = S_JRD;
        end
      end
      S_JRD: begin
        cap_p     = 1'b1;
        k_nxt     = 2'd0;
        nacc_nxt  = 1'b0;
        pacc_nxt  = 1'b0;
        state_nxt = S_XS;
      end
      S_XS: begin
        x_start   = 1'b1;
        state_nxt = S_XW;
      end
      S_XW: begin
        if (xres.done) begin
          nacc_nxt = nacc_r || xres.neg;
          pacc_nxt = pacc_r || xres.pos;
          if (k_r == 2'd2) begin
            k_nxt = 2'd0;
            if (!((nacc_r || xres.neg) && (pacc_r || xres.pos))) begin
              state_nxt = S_NEXTI;
            end else begin
              j_nxt     = j_r + CW'(1);
              state_nxt = S_JCHK;
            end
          end else begin
            k_nxt     = k_r + 2'd1;
            state_nxt = S_XS;
          end
        end
      end
      S_NEXTI: begin
        if (i_r + CW'(1) == n_r) begin
          inc_nxt   = 1'b1;
          state_nxt = S_FIN;
        end else begin
          i_nxt     = i_r + CW'(1);
          state_nxt = S_R0;
        end
      end
      S_EMIT: begin
        if (!pend_v_r || out_free) begin
          out_load   = pend_v_r;
          cap_pend   = 1'b1;
          pend_v_nxt = 1'b1;
          s_nxt      = i_r + CW'(1);
          state_nxt  = S_SHR;
        end
      end
      S_SHR: begin
        raddr = s_r[IW-1:0];
        if (s_r == n_r) begin
          n_nxt     = n_r - CW'(1);
          state_nxt = S_START;
        end else begin
          state_nxt = S_SHW;
        end
      end
      S_SHW: begin
        we        = 1'b1;
        waddr     = IW'(s_r - CW'(1));
        wdata     = rdata;
        s_nxt     = s_r + CW'(1);
        state_nxt = S_SHR;
      end
      S_FIN: begin
        if (out_free) begin
          out_load   = 1'b1;
          oinc_nxt   = inc_r;
          olast_nxt  = 1'b1;
          pend_v_nxt = 1'b0;
          cnt_nxt    = '0;
          ovf_nxt    = 1'b0;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      k_r         <= 2'd0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      ovf_r    <= ovf_nxt;
      pend_v_r <= pend_v_nxt;
      k_r      <= k_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    s_r    <= s_nxt;
    inc_r  <= inc_nxt;
    nacc_r <= nacc_nxt;
    pacc_r <= pacc_nxt;
    if (cap_a) a_r <= rdata;
    if (cap_b) b_r <= rdata;
    if (cap_c) c_r <= rdata;
    if (cap_p) p_r <= rdata;
    if (cap_pend) begin
      pa_r <= a_r;
      pb_r <= b_r;
      pc_r <= c_r;
    end
    if (out_load) begin
      of_r    <= of_nxt;
      om_r    <= om_nxt;
      ot_r    <= ot_nxt;
      otv_r   <= otv_nxt;
      oinc_r  <= oinc_nxt;
      olast_r <= olast_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_first_x        = of_r.x;
  assign out_first_y        = of_r.y;
  assign out_middle_x       = om_r.x;
  assign out_middle_y       = om_r.y;
  assign out_third_x        = ot_r.x;
  assign out_third_y        = ot_r.y;
  assign out_triangle_valid = otv_r;
  assign out_incomplete     = oinc_r;
  assign out_last_triangle  = olast_r;

endmodule

// ----- hw/rtl/ect_ram.sv -----
// ---------------------------------------------------------------------------
// ect_ram
// Generic single write, single read RAM with registered read data.
// ---------------------------------------------------------------------------
module ect_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/ect_cross.sv -----
// ---------------------------------------------------------------------------
// ect_cross
// Sign of (b-a)x(c-a), both products taken in turn on one shared 17x17 multiplier.
// ---------------------------------------------------------------------------
module ect_cross (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  ect_pkg::point_t a,
  input  ect_pkg::point_t b,
  input  ect_pkg::point_t c,
  output ect_pkg::cross_res_t res
);
  import ect_pkg::*;

  logic signed [CoordW:0]     ux_r, uy_r, vx_r, vy_r;
  logic signed [2*CoordW+1:0] p1_r, p2_r, prod;
  logic signed [2*CoordW+2:0] diff;
  logic [1:0]                 cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, neg_r, pos_r;
  logic signed [CoordW:0]     m_a, m_b;

  assign m_a  = (cnt_r == 2'd0) ? ux_r : uy_r;
  assign m_b  = (cnt_r == 2'd0) ? vy_r : vx_r;
  assign prod = m_a * m_b;
  assign diff = {p1_r[2*CoordW+1], p1_r} - {p2_r[2*CoordW+1], p2_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 2'd0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 2'd1;
      if (cnt_r == 2'd2) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 2'd0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      done_r <= busy_r && (cnt_r == 2'd2);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ux_r <= {b.x[CoordW-1], b.x} - {a.x[CoordW-1], a.x};
      uy_r <= {b.y[CoordW-1], b.y} - {a.y[CoordW-1], a.y};
      vx_r <= {c.x[CoordW-1], c.x} - {a.x[CoordW-1], a.x};
      vy_r <= {c.y[CoordW-1], c.y} - {a.y[CoordW-1], a.y};
    end else if (busy_r) begin
      case (cnt_r)
        2'd0: p1_r <= prod;
        2'd1: p2_r <= prod;
        default: begin
          neg_r <= diff < 0;
          pos_r <= diff > 0;
        end
      endcase
    end
  end

  assign res.done = done_r;
  assign res.neg  = neg_r;
  assign res.pos  = pos_r;

endmodule
